/* hw/rtl/hbdma_pkg.sv */
// Shared types, control word field positions and address stepping for the hblank DMA engine.
package hbdma_pkg;

   typedef enum logic [1:0] {
      FUNC_ARM   = 2'd0,
      FUNC_STOP  = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_INC    = 2'd0,
      MODE_DEC    = 2'd1,
      MODE_FIXED  = 2'd2,
      MODE_RELOAD = 2'd3
   } addr_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RUN
   } state_type;

   localparam int CTL_ENABLE_BIT   = 31;
   localparam int CTL_START_HI     = 29;
   localparam int CTL_START_LO     = 28;
   localparam int CTL_WIDE_BIT     = 26;
   localparam int CTL_SMODE_HI     = 24;
   localparam int CTL_SMODE_LO     = 23;
   localparam int CTL_DMODE_HI     = 22;
   localparam int CTL_DMODE_LO     = 21;
   localparam int CTL_COUNT_HI     = 15;
   localparam int COUNT_W          = 16;
   localparam logic [1:0] START_HBLANK = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  channel;
      logic [31:0] src_addr;
      logic [31:0] dest_addr;
      logic [31:0] control_word;
   } req_type;

   typedef struct packed {
      logic [31:0] xfer_src;
      logic [31:0] xfer_dest;
      logic        wide;
      logic [1:0]  from_channel;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dest;
      logic [31:0] control;
   } chan_entry_type;

   function automatic logic [31:0] step_addr(input logic [31:0] addr,
                                             input logic [1:0]  mode,
                                             input logic        wide);
      logic [31:0] unit;
      unit = wide ? 32'd4 : 32'd2;
      case (mode)
         MODE_DEC:   step_addr = addr - unit;
         MODE_FIXED: step_addr = addr;
         default:    step_addr = addr + unit;
      endcase
   endfunction

endpackage

/* hw/rtl/hblank_dma_channel_engine_top.sv */
// Top level of the hblank DMA engine: command decode, channel live flags, memory and sequencer.
//
//   channel   ports                         transfer when
//   request   start, busy, req_data         start & !busy
//   result    rsp_valid, rsp_data           rsp_valid (one cycle, no back-pressure)
//
// Arm and stop complete in the accept cycle; busy does not rise.
// A tick with no live channel emits nothing and busy does not rise.
// A tick over live channels keeps busy high while the sequencer does, for
// each live channel in turn, one memory read and then its transfers, one
// transfer per cycle. Each channel gives at most MAX_COUNT transfers.
// Reset clears the live flags and the sequencer; the memory needs no clearing.
module hblank_dma_channel_engine_top #(
   parameter int NUM_CHANNELS = 4,
   parameter int MAX_COUNT    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hbdma_pkg::req_type   req_data,
   output logic                 rsp_valid,
   output hbdma_pkg::rsp_type   rsp_data
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [NUM_CHANNELS-1:0]     live_ff, live_in;
   logic                        accept;
   logic                        chan_ok;
   logic [CH_W-1:0]             req_ch;
   logic                        is_arm, is_stop, is_tick;
   logic                        arm_live;

   logic [CH_W-1:0]             rd_addr;
   hbdma_pkg::chan_entry_type   rd_data;
   logic                        wb_en;
   logic [CH_W-1:0]             wb_addr;
   hbdma_pkg::chan_entry_type   wb_data;

   logic                        mem_wr_en;
   logic [CH_W-1:0]             mem_wr_addr;
   hbdma_pkg::chan_entry_type   mem_wr_data;
   hbdma_pkg::chan_entry_type   arm_entry;

   assign accept  = start && !busy;
   assign chan_ok = (32'(req_data.channel) < NUM_CHANNELS);
   assign req_ch  = CH_W'(req_data.channel);
   assign is_arm  = accept && chan_ok && (req_data.func == hbdma_pkg::FUNC_ARM);
   assign is_stop = accept && chan_ok && (req_data.func == hbdma_pkg::FUNC_STOP);
   assign is_tick = accept && (req_data.func == hbdma_pkg::FUNC_TICK);

   assign arm_live = req_data.control_word[hbdma_pkg::CTL_ENABLE_BIT] &&
                     (req_data.control_word[hbdma_pkg::CTL_START_HI:hbdma_pkg::CTL_START_LO]
                        == hbdma_pkg::START_HBLANK) &&
                     (req_data.control_word[hbdma_pkg::CTL_COUNT_HI:0] != '0);

   always_comb begin
      live_in = live_ff;
      if (is_arm) begin
         live_in[req_ch] = arm_live;
      end else if (is_stop) begin
         live_in[req_ch] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign arm_entry.src     = req_data.src_addr;
   assign arm_entry.dest    = req_data.dest_addr;
   assign arm_entry.control = req_data.control_word;

   assign mem_wr_en   = is_arm || wb_en;
   assign mem_wr_addr = wb_en ? wb_addr : req_ch;
   assign mem_wr_data = wb_en ? wb_data : arm_entry;

   hbdma_chan_mem #(
      .DEPTH (NUM_CHANNELS),
      .AW    (CH_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hbdma_seq #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .MAX_COUNT    (MAX_COUNT),
      .CH_W         (CH_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .tick_go   (is_tick),
      .live      (live_ff),
      .rd_data   (rd_data),
      .rd_addr   (rd_addr),
      .wb_en     (wb_en),
      .wb_addr   (wb_addr),
      .wb_data   (wb_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/hbdma_chan_mem.sv */
// Channel state memory: one write port, one registered read port.
module hbdma_chan_mem #(
   parameter int DEPTH = 4,
   parameter int AW    = 2
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  hbdma_pkg::chan_entry_type      wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output hbdma_pkg::chan_entry_type      rd_data
);

   hbdma_pkg::chan_entry_type mem [DEPTH];
   hbdma_pkg::chan_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/hbdma_seq.sv */
// Tick sequencer: walks live channels, emits one transfer per cycle within a channel, writes addresses back.
module hbdma_seq #(
   parameter int NUM_CHANNELS = 4,
   parameter int MAX_COUNT    = 16,
   parameter int CH_W         = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick_go,
   input  logic [NUM_CHANNELS-1:0]     live,
   input  hbdma_pkg::chan_entry_type   rd_data,
   output logic [CH_W-1:0]             rd_addr,
   output logic                        wb_en,
   output logic [CH_W-1:0]             wb_addr,
   output hbdma_pkg::chan_entry_type   wb_data,
   output logic                        busy,
   output logic                        rsp_valid,
   output hbdma_pkg::rsp_type          rsp_data
);

   localparam int CW = $clog2(MAX_COUNT + 1);
   localparam logic [hbdma_pkg::COUNT_W-1:0] MAX_CNT16 = hbdma_pkg::COUNT_W'(MAX_COUNT);

   hbdma_pkg::state_type       state_ff, state_in;
   logic [NUM_CHANNELS-1:0]    mask_ff, mask_in;
   logic [CH_W-1:0]            chan_ff, chan_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [31:0]                src_ff, src_in;
   logic [31:0]                dest_ff, dest_in;
   logic [31:0]                ctl_ff, ctl_in;

   logic [NUM_CHANNELS-1:0]    pool;
   logic [CH_W-1:0]            pick;
   logic [NUM_CHANNELS-1:0]    pick_bit;
   logic [hbdma_pkg::COUNT_W-1:0] raw_cnt;
   logic                       wide;
   logic [1:0]                 smode, dmode;
   logic [31:0]                src_next, dest_next;
   logic                       chan_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbdma_pkg::ST_IDLE;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
      end
      chan_ff <= chan_in;
      cnt_ff  <= cnt_in;
      src_ff  <= src_in;
      dest_ff <= dest_in;
      ctl_ff  <= ctl_in;
   end

   always_comb begin
      pool = (state_ff == hbdma_pkg::ST_IDLE) ? live : mask_ff;
      pick = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (pool[i]) begin
            pick = CH_W'(i);
         end
      end
      pick_bit = '0;
      pick_bit[pick] = 1'b1;
   end

   assign rd_addr = pick;

   assign raw_cnt   = rd_data.control[hbdma_pkg::CTL_COUNT_HI:0];
   assign wide      = ctl_ff[hbdma_pkg::CTL_WIDE_BIT];
   assign smode     = ctl_ff[hbdma_pkg::CTL_SMODE_HI:hbdma_pkg::CTL_SMODE_LO];
   assign dmode     = ctl_ff[hbdma_pkg::CTL_DMODE_HI:hbdma_pkg::CTL_DMODE_LO];
   assign src_next  = hbdma_pkg::step_addr(src_ff, smode, wide);
   assign dest_next = (dmode == hbdma_pkg::MODE_RELOAD) ? dest_ff
                                                      : hbdma_pkg::step_addr(dest_ff, dmode, wide);
   assign chan_done = (cnt_ff == CW'(1));

   always_comb begin
      state_in  = state_ff;
      mask_in   = mask_ff;
      chan_in   = chan_ff;
      cnt_in    = cnt_ff;
      src_in    = src_ff;
      dest_in   = dest_ff;
      ctl_in    = ctl_ff;
      rsp_valid = 1'b0;
      wb_en     = 1'b0;
      case (state_ff)
         hbdma_pkg::ST_IDLE: begin
            if (tick_go && (live != '0)) begin
               chan_in  = pick;
               mask_in  = live & ~pick_bit;
               state_in = hbdma_pkg::ST_FETCH;
            end
         end
         hbdma_pkg::ST_FETCH: begin
            src_in   = rd_data.src;
            dest_in  = rd_data.dest;
            ctl_in   = rd_data.control;
            cnt_in   = (raw_cnt > MAX_CNT16) ? CW'(MAX_COUNT) : raw_cnt[CW-1:0];
            state_in = hbdma_pkg::ST_RUN;
         end
         hbdma_pkg::ST_RUN: begin
            rsp_valid = 1'b1;
            src_in    = src_next;
            dest_in   = dest_next;
            cnt_in    = cnt_ff - CW'(1);
            if (chan_done) begin
               wb_en = 1'b1;
               if (mask_ff != '0) begin
                  chan_in  = pick;
                  mask_in  = mask_ff & ~pick_bit;
                  state_in = hbdma_pkg::ST_FETCH;
               end else begin
                  state_in = hbdma_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = hbdma_pkg::ST_IDLE;
         end
      endcase
   end

   assign wb_addr         = chan_ff;
   assign wb_data.src     = src_next;
   assign wb_data.dest    = dest_next;
   assign wb_data.control = ctl_ff;

   assign busy                  = (state_ff != hbdma_pkg::ST_IDLE);
   assign rsp_data.xfer_src     = src_ff;
   assign rsp_data.xfer_dest    = dest_ff;
   assign rsp_data.wide         = wide;
   assign rsp_data.from_channel = 2'(chan_ff);
   assign rsp_data.last         = chan_done && (mask_ff == '0);

endmodule
